[hdl/tblc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tblc_pkg;

    localparam int NUM_SETS   = 64;
    localparam int NUM_WAYS   = 4;
    localparam int BLK_BITS   = 2;
    localparam int BLOCK_SIDE = 1 << BLK_BITS;
    localparam int COORD_BITS = 12;

    localparam int SET_BITS     = $clog2(NUM_SETS);
    localparam int WAY_BITS     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int SLOTS        = NUM_SETS * NUM_WAYS;
    localparam int SLOT_BITS    = $clog2(SLOTS);
    localparam int OFF_BITS     = 2 * BLK_BITS;
    localparam int BLOCK_TEXELS = 1 << OFF_BITS;
    localparam int DADDR_BITS   = SLOT_BITS + OFF_BITS;
    localparam int DATA_DEPTH   = SLOTS * BLOCK_TEXELS;
    localparam int BX_BITS      = COORD_BITS - BLK_BITS;

    localparam int TEX_W   = 16;
    localparam int LVL_W   = 4;
    localparam int CRD_W   = 12;
    localparam int DIM_W   = 13;
    localparam int TEXEL_W = 32;
    localparam int REQ_W   = 10;
    localparam int STAMP_W = 64;

    typedef enum logic [1:0] {
        ST_HIT    = 2'd0,
        ST_MISS   = 2'd1,
        ST_DONE   = 2'd2,
        ST_REJECT = 2'd3
    } status_t;

    typedef struct packed {
        logic               op;
        logic [TEX_W-1:0]   texture_id;
        logic [LVL_W-1:0]   level;
        logic [CRD_W-1:0]   coord_x;
        logic [CRD_W-1:0]   coord_y;
        logic [DIM_W-1:0]   level_width;
        logic [DIM_W-1:0]   level_height;
        logic               level_present;
        logic [TEXEL_W-1:0] fill_texel;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [TEXEL_W-1:0] out_texel;
        logic [TEX_W-1:0]   req_texture_id;
        logic [LVL_W-1:0]   req_level;
        logic [REQ_W-1:0]   req_block_x;
        logic [REQ_W-1:0]   req_block_y;
    } out_item_t;

    typedef struct packed {
        logic [TEX_W-1:0]   tex;
        logic [LVL_W-1:0]   lvl;
        logic [BX_BITS-1:0] bx;
        logic [BX_BITS-1:0] by;
        logic [STAMP_W-1:0] stamp;
    } way_tag_t;

    typedef way_tag_t [NUM_WAYS-1:0] tag_row_t;

    typedef struct packed {
        logic reject;
        logic lookup;
        logic fill;
        logic resolve;
        logic data_out;
    } cmd_t;

    typedef struct packed {
        logic reject;
        logic in_fill;
        logic fill_last;
        logic hit;
    } stat_t;

    function automatic logic [SET_BITS-1:0] set_index(
        input logic [TEX_W-1:0]   tex,
        input logic [LVL_W-1:0]   lvl,
        input logic [BX_BITS-1:0] bx,
        input logic [BX_BITS-1:0] by
    );
        logic [31:0] h;
        h = 32'(tex) ^ 32'(lvl) ^ 32'(bx) ^ (32'(by) << 1);
        return h[SET_BITS-1:0];
    endfunction

    function automatic logic [SLOT_BITS-1:0] slot_of(
        input logic [SET_BITS-1:0] set,
        input logic [WAY_BITS-1:0] way
    );
        logic [31:0] s;
        s = 32'(set) * NUM_WAYS + 32'(way);
        return s[SLOT_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

[hdl/tblc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module tblc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire tblc_pkg::stat_t st,
    output tblc_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_DATA = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (st.reject)
                    begin
                        cmd.reject = 1'b1;
                        state_next = S_OUT;
                    end
                    else if (st.in_fill)
                    begin
                        cmd.fill = 1'b1;
                        if (st.fill_last)
                        begin
                            state_next = S_DATA;
                        end
                    end
                    else
                    begin
                        cmd.lookup = 1'b1;
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                cmd.resolve = 1'b1;
                state_next  = st.hit ? S_DATA : S_OUT;
            end
            S_DATA:
            begin
                cmd.data_out = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    a_look_follows_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |=> (state_reg == S_LOOK))
        else $error("lookup did not enter tag compare");
    a_data_after: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DATA) |=> (state_reg == S_OUT))
        else $error("data read not delivered");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

endmodule
`default_nettype wire

[hdl/tblc_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
module tblc_dpath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tblc_pkg::in_item_t in_item,
    input  wire tblc_pkg::cmd_t     cmd,
    output tblc_pkg::stat_t         st,
    output tblc_pkg::out_item_t     out_item
);

    tblc_pkg::tag_row_t tag_mem [tblc_pkg::NUM_SETS];
    tblc_pkg::tag_row_t row_q;
    tblc_pkg::tag_row_t row_wr;
    logic [tblc_pkg::TEXEL_W-1:0] data_mem [tblc_pkg::DATA_DEPTH];
    logic [tblc_pkg::TEXEL_W-1:0] rd_q;

    logic [tblc_pkg::SLOTS-1:0]     valid_reg, valid_next;
    logic [tblc_pkg::STAMP_W-1:0]   count_reg, count_next;
    logic                           pending_reg, pending_next;
    logic [tblc_pkg::OFF_BITS-1:0]  pos_reg, pos_next;

    logic [tblc_pkg::TEX_W-1:0]     tex_reg;
    logic [tblc_pkg::LVL_W-1:0]     lvl_reg;
    logic [tblc_pkg::BX_BITS-1:0]   bx_reg, by_reg;
    logic [tblc_pkg::OFF_BITS-1:0]  off_reg;
    logic [tblc_pkg::SET_BITS-1:0]  set_reg;
    logic [tblc_pkg::DIM_W-1:0]     w_reg, h_reg;
    logic                           pres_reg;

    logic [tblc_pkg::SLOT_BITS-1:0] pslot_reg;
    logic [tblc_pkg::OFF_BITS-1:0]  poff_reg;
    logic [tblc_pkg::BX_BITS-1:0]   pbx_reg, pby_reg;
    logic [tblc_pkg::DIM_W-1:0]     pw_reg, ph_reg;
    logic                           ppres_reg;

    logic                           byp_reg;
    logic [tblc_pkg::TEXEL_W-1:0]   byp_val_reg;
    logic [1:0]                     kind_reg;
    tblc_pkg::out_item_t            out_reg;

    logic [tblc_pkg::COORD_BITS-1:0] cx, cy;
    logic [tblc_pkg::BX_BITS-1:0]    in_bx, in_by;
    logic [tblc_pkg::OFF_BITS-1:0]   in_off;
    logic [tblc_pkg::SET_BITS-1:0]   in_set;

    logic [tblc_pkg::NUM_WAYS-1:0]  hit_vec;
    logic [tblc_pkg::WAY_BITS-1:0]  hit_way, victim;
    logic [tblc_pkg::STAMP_W-1:0]   oldest;
    logic                           found;
    logic [tblc_pkg::SLOT_BITS-1:0] hit_slot, vic_slot;

    logic [tblc_pkg::BLK_BITS-1:0]   f_row, f_col;
    logic [tblc_pkg::COORD_BITS-1:0] f_tx, f_ty;
    logic [tblc_pkg::TEXEL_W-1:0]    f_val;
    logic                            fill_last;

    logic                            rd_en;
    logic [tblc_pkg::DADDR_BITS-1:0] rd_addr;

    assign cx     = in_item.coord_x[tblc_pkg::COORD_BITS-1:0];
    assign cy     = in_item.coord_y[tblc_pkg::COORD_BITS-1:0];
    assign in_bx  = cx[tblc_pkg::COORD_BITS-1:tblc_pkg::BLK_BITS];
    assign in_by  = cy[tblc_pkg::COORD_BITS-1:tblc_pkg::BLK_BITS];
    assign in_off = {cy[tblc_pkg::BLK_BITS-1:0], cx[tblc_pkg::BLK_BITS-1:0]};
    assign in_set = tblc_pkg::set_index(in_item.texture_id, in_item.level, in_bx, in_by);

    assign fill_last = (pos_reg == tblc_pkg::OFF_BITS'(tblc_pkg::BLOCK_TEXELS - 1));
    assign f_row = pos_reg[tblc_pkg::OFF_BITS-1:tblc_pkg::BLK_BITS];
    assign f_col = pos_reg[tblc_pkg::BLK_BITS-1:0];
    assign f_tx  = {pbx_reg, f_col};
    assign f_ty  = {pby_reg, f_row};
    assign f_val = (ppres_reg && (tblc_pkg::DIM_W'(f_tx) < pw_reg)
                    && (tblc_pkg::DIM_W'(f_ty) < ph_reg)) ? in_item.fill_texel : '0;

    assign st.reject    = (in_item.op != pending_reg);
    assign st.in_fill   = in_item.op;
    assign st.fill_last = fill_last;
    assign st.hit       = |hit_vec;

    always_comb
    begin
        hit_vec = '0;
        hit_way = '0;
        victim  = '0;
        oldest  = row_q[0].stamp;
        found   = 1'b0;
        for (int w = 0; w < tblc_pkg::NUM_WAYS; w++)
        begin
            hit_vec[w] = valid_reg[tblc_pkg::slot_of(set_reg, tblc_pkg::WAY_BITS'(w))]
                && (row_q[w].tex == tex_reg) && (row_q[w].lvl == lvl_reg)
                && (row_q[w].bx == bx_reg) && (row_q[w].by == by_reg);
            if (hit_vec[w])
            begin
                hit_way = tblc_pkg::WAY_BITS'(w);
            end
        end
        for (int w = 0; w < tblc_pkg::NUM_WAYS; w++)
        begin
            if (!found)
            begin
                if (!valid_reg[tblc_pkg::slot_of(set_reg, tblc_pkg::WAY_BITS'(w))])
                begin
                    victim = tblc_pkg::WAY_BITS'(w);
                    found  = 1'b1;
                end
                else if (row_q[w].stamp < oldest)
                begin
                    oldest = row_q[w].stamp;
                    victim = tblc_pkg::WAY_BITS'(w);
                end
            end
        end
    end

    assign hit_slot = tblc_pkg::slot_of(set_reg, hit_way);
    assign vic_slot = tblc_pkg::slot_of(set_reg, victim);

    always_comb
    begin
        row_wr = row_q;
        if (st.hit)
        begin
            row_wr[hit_way].stamp = count_reg;
        end
        else
        begin
            row_wr[victim] = '{tex: tex_reg, lvl: lvl_reg, bx: bx_reg, by: by_reg,
                               stamp: count_reg};
        end
    end

    assign rd_en   = (cmd.resolve && st.hit) || (cmd.fill && fill_last);
    assign rd_addr = cmd.resolve ? {hit_slot, off_reg} : {pslot_reg, poff_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            row_q <= tag_mem[in_set];
        end
        if (cmd.resolve)
        begin
            tag_mem[set_reg] <= row_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill)
        begin
            data_mem[{pslot_reg, pos_reg}] <= f_val;
        end
        if (rd_en)
        begin
            rd_q <= data_mem[rd_addr];
        end
    end

    always_comb
    begin
        valid_next   = valid_reg;
        count_next   = count_reg;
        pending_next = pending_reg;
        pos_next     = pos_reg;
        if (cmd.lookup)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.resolve && !st.hit)
        begin
            valid_next[vic_slot] = 1'b1;
            pending_next         = 1'b1;
            pos_next             = '0;
        end
        if (cmd.fill)
        begin
            pos_next = pos_reg + 1'b1;
            if (fill_last)
            begin
                pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            count_reg   <= '0;
            pending_reg <= 1'b0;
            pos_reg     <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
            pos_reg     <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            tex_reg  <= in_item.texture_id;
            lvl_reg  <= in_item.level;
            bx_reg   <= in_bx;
            by_reg   <= in_by;
            off_reg  <= in_off;
            set_reg  <= in_set;
            w_reg    <= in_item.level_width;
            h_reg    <= in_item.level_height;
            pres_reg <= in_item.level_present;
        end
        if (cmd.resolve && !st.hit)
        begin
            pslot_reg <= vic_slot;
            poff_reg  <= off_reg;
            pbx_reg   <= bx_reg;
            pby_reg   <= by_reg;
            pw_reg    <= w_reg;
            ph_reg    <= h_reg;
            ppres_reg <= pres_reg;
        end
        if (cmd.resolve && st.hit)
        begin
            byp_reg  <= 1'b0;
            kind_reg <= tblc_pkg::ST_HIT;
        end
        if (cmd.fill && fill_last)
        begin
            byp_reg     <= (poff_reg == pos_reg);
            byp_val_reg <= f_val;
            kind_reg    <= tblc_pkg::ST_DONE;
        end
        if (cmd.reject)
        begin
            out_reg <= '{status: tblc_pkg::ST_REJECT, out_texel: '0, req_texture_id: '0,
                         req_level: '0, req_block_x: '0, req_block_y: '0};
        end
        else if (cmd.resolve && !st.hit)
        begin
            out_reg <= '{status: tblc_pkg::ST_MISS, out_texel: '0,
                         req_texture_id: tex_reg, req_level: lvl_reg,
                         req_block_x: tblc_pkg::REQ_W'(bx_reg),
                         req_block_y: tblc_pkg::REQ_W'(by_reg)};
        end
        else if (cmd.data_out)
        begin
            out_reg <= '{status: kind_reg, out_texel: (byp_reg ? byp_val_reg : rd_q),
                         req_texture_id: '0, req_level: '0, req_block_x: '0,
                         req_block_y: '0};
        end
    end

    assign out_item = out_reg;

    a_pos_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != '0) |-> pending_reg)
        else $error("fill position advanced with no block pending");
    a_miss_arms_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.resolve && !st.hit) |=> (pending_reg && pos_reg == '0))
        else $error("miss did not arm a fill");
    a_last_fill_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fill && fill_last) |=> !pending_reg)
        else $error("last fill left block pending");
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.resolve |-> $onehot0(hit_vec))
        else $error("duplicate tag within a set");

endmodule
`default_nettype wire

[hdl/texture_block_cache_lru_unit.sv]
// A lookup hit passes tag compare (S_LOOK) and data read (S_DATA) before its result (S_OUT);
// a miss goes from S_LOOK to S_OUT, a reject goes straight to S_OUT. A fill item is taken
// in S_IDLE without leaving it; the last fill of a block passes S_DATA before its result.
// One item at a time: the next item is accepted the cycle after the result is taken.
// Reset (rst_n low, asynchronous) clears the way valid bits, stamp counter and fill state.
`timescale 1ns / 1ps
`default_nettype none
module texture_block_cache_lru_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire tblc_pkg::in_item_t in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output tblc_pkg::out_item_t     out_item
);

    tblc_pkg::cmd_t  cmd;
    tblc_pkg::stat_t st;

    tblc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    tblc_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cmd      (cmd),
        .st       (st),
        .out_item (out_item)
    );

endmodule
`default_nettype wire

[dv/texture_block_cache_lru_unit_tb.sv]
`timescale 1ns / 1ps
module texture_block_cache_lru_unit_tb;
    import tblc_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    texture_block_cache_lru_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    localparam int FILL_OP   = 1;
    localparam int LOOKUP_OP = 0;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // cache mirror
    logic                 m_valid [SLOTS];
    logic [TEX_W-1:0]     m_tex   [SLOTS];
    logic [LVL_W-1:0]     m_lvl   [SLOTS];
    logic [BX_BITS-1:0]   m_bx    [SLOTS];
    logic [BX_BITS-1:0]   m_by    [SLOTS];
    logic [STAMP_W-1:0]   m_stamp [SLOTS];
    logic [TEXEL_W-1:0]   m_data  [DATA_DEPTH];
    logic [STAMP_W-1:0]   m_clock;
    logic                 m_pending;
    int                   m_pos;
    int                   m_slot;
    int                   m_off;
    int                   m_pbx;
    int                   m_pby;
    int                   m_pw;
    int                   m_ph;
    logic                 m_present;

    out_item_t expected_results[$];
    int        mismatches;
    int        sent_count;
    int        burst_left;
    bit        done_sending;
    bit        long_hold;

    function automatic out_item_t blank_result(status_t st);
        out_item_t r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    task automatic mirror_reset();
        for (int i = 0; i < SLOTS; i++)
        begin
            m_valid[i] = 1'b0;
            m_tex[i] = '0;
            m_lvl[i] = '0;
            m_bx[i] = '0;
            m_by[i] = '0;
            m_stamp[i] = '0;
        end
        for (int i = 0; i < DATA_DEPTH; i++)
            m_data[i] = '0;
        m_clock = '0;
        m_pending = 1'b0;
        m_pos = 0;
        m_slot = 0;
        m_off = 0;
        m_pbx = 0;
        m_pby = 0;
        m_pw = 0;
        m_ph = 0;
        m_present = 1'b0;
    endtask

    // returns 1 when a result is produced
    function automatic bit predict_cache(in_item_t it, output out_item_t r);
        int bx, by, off, set, base, victim, s, tx, ty;
        logic [STAMP_W-1:0] oldest;
        logic [TEXEL_W-1:0] v;
        r = '0;
        if (it.op != m_pending)
        begin
            r = blank_result(ST_REJECT);
            return 1;
        end
        if (it.op == FILL_OP)
        begin
            tx = m_pbx * BLOCK_SIDE + m_pos % BLOCK_SIDE;
            ty = m_pby * BLOCK_SIDE + m_pos / BLOCK_SIDE;
            v = (m_present && tx < m_pw && ty < m_ph) ? it.fill_texel : '0;
            m_data[m_slot * BLOCK_TEXELS + m_pos] = v;
            m_pos++;
            if (m_pos < BLOCK_TEXELS)
                return 0;
            m_pending = 1'b0;
            m_pos = 0;
            r = blank_result(ST_DONE);
            r.out_texel = m_data[m_slot * BLOCK_TEXELS + m_off];
            return 1;
        end
        bx = int'(it.coord_x) / BLOCK_SIDE;
        by = int'(it.coord_y) / BLOCK_SIDE;
        off = (int'(it.coord_y) % BLOCK_SIDE) * BLOCK_SIDE + int'(it.coord_x) % BLOCK_SIDE;
        set = (int'(it.texture_id) ^ int'(it.level) ^ bx ^ (by << 1)) & (NUM_SETS - 1);
        base = set * NUM_WAYS;
        m_clock++;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            s = base + w;
            if (m_valid[s] && m_tex[s] == it.texture_id && m_lvl[s] == it.level
                && m_bx[s] == bx && m_by[s] == by)
            begin
                m_stamp[s] = m_clock;
                r = blank_result(ST_HIT);
                r.out_texel = m_data[s * BLOCK_TEXELS + off];
                return 1;
            end
        end
        victim = 0;
        oldest = m_stamp[base];
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            s = base + w;
            if (!m_valid[s])
            begin
                victim = w;
                break;
            end
            if (m_stamp[s] < oldest)
            begin
                oldest = m_stamp[s];
                victim = w;
            end
        end
        s = base + victim;
        m_valid[s] = 1'b1;
        m_tex[s] = it.texture_id;
        m_lvl[s] = it.level;
        m_bx[s] = BX_BITS'(bx);
        m_by[s] = BX_BITS'(by);
        m_stamp[s] = m_clock;
        m_pending = 1'b1;
        m_pos = 0;
        m_slot = s;
        m_off = off;
        m_pbx = bx;
        m_pby = by;
        m_pw = int'(it.level_width);
        m_ph = int'(it.level_height);
        m_present = it.level_present;
        r = blank_result(ST_MISS);
        r.req_texture_id = it.texture_id;
        r.req_level = it.level;
        r.req_block_x = REQ_W'(bx);
        r.req_block_y = REQ_W'(by);
        return 1;
    endfunction

    task automatic send_item(in_item_t it, bit has_fixed, out_item_t fixed);
        out_item_t r;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
        if (predict_cache(it, r))
        begin
            if (has_fixed && fixed != r)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row mismatch: model %h typed %h", r, fixed);
            end
            expected_results.push_back(r);
        end
    endtask

    function automatic in_item_t make_lookup(int tex, int lvl, int x, int y, int w, int h,
                                             bit present);
        in_item_t it;
        it = '0;
        it.op = 1'(LOOKUP_OP);
        it.texture_id = TEX_W'(tex);
        it.level = LVL_W'(lvl);
        it.coord_x = CRD_W'(x);
        it.coord_y = CRD_W'(y);
        it.level_width = DIM_W'(w);
        it.level_height = DIM_W'(h);
        it.level_present = present;
        return it;
    endfunction

    function automatic in_item_t make_fill(logic [TEXEL_W-1:0] v);
        in_item_t it;
        it = '0;
        it.op = 1'(FILL_OP);
        it.texture_id = TEX_W'($urandom);
        it.level = LVL_W'($urandom);
        it.coord_x = CRD_W'($urandom);
        it.coord_y = CRD_W'($urandom);
        it.level_width = DIM_W'($urandom_range(0, 4096));
        it.level_height = DIM_W'($urandom_range(0, 4096));
        it.level_present = 1'($urandom_range(0, 1));
        it.fill_texel = v;
        return it;
    endfunction

    task automatic fill_block(bit noisy);
        for (int i = 0; i < BLOCK_TEXELS; i++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_item(make_lookup($urandom_range(0, 65535), $urandom_range(0, 15),
                                      $urandom_range(0, 4095), $urandom_range(0, 4095),
                                      $urandom_range(0, 4096), $urandom_range(0, 4096),
                                      1'($urandom_range(0, 1))), 0, '0);
            send_item(make_fill($urandom), 0, '0);
        end
    endtask

    typedef struct {
        in_item_t  it;
        bit        has_fixed;
        out_item_t fixed;
    } table_row_t;

    table_row_t directed_rows[$];

    task automatic add_row(in_item_t it, bit has_fixed, out_item_t fixed);
        table_row_t row;
        row.it = it;
        row.has_fixed = has_fixed;
        row.fixed = fixed;
        directed_rows.push_back(row);
    endtask

    task automatic build_table();
        out_item_t miss_max;
        miss_max = blank_result(ST_MISS);
        miss_max.req_texture_id = 16'hFFFF;
        miss_max.req_level = 4'hF;
        miss_max.req_block_x = 10'h3FF;
        miss_max.req_block_y = 10'h3FF;
        add_row(make_fill(32'hFFFF_FFFF), 1, blank_result(ST_REJECT));
        add_row(make_lookup(16'hFFFF, 15, 4095, 4095, 4096, 4096, 1), 1, miss_max);
        add_row(make_lookup(0, 0, 0, 0, 0, 0, 0), 1, blank_result(ST_REJECT));
        for (int i = 0; i < BLOCK_TEXELS; i++)
            add_row(make_fill(i[0] ? 32'hFFFF_FFFF : 32'h0), 0, '0);
        add_row(make_lookup(16'hFFFF, 15, 4094, 4093, 0, 0, 0), 0, '0);
        add_row(make_lookup(0, 0, 0, 0, 2, 3, 1), 1, blank_result(ST_MISS));
    endtask

    // small id pool so hits and evictions are frequent
    task automatic random_lookup();
        int tex, lvl, x, y;
        tex = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 5);
        lvl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 1);
        x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 15);
        y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 15);
        send_item(make_lookup(tex, lvl, x, y,
                              ($urandom_range(0, 3) == 0) ? 4096 : $urandom_range(0, 20),
                              ($urandom_range(0, 3) == 0) ? 4096 : $urandom_range(0, 20),
                              $urandom_range(0, 4) != 0), 0, '0);
        if (m_pending)
            fill_block(1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        done_sending = 1'b0;
        mismatches = 0;
        sent_count = 0;
        burst_left = 0;
        mirror_reset();
        build_table();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            send_item(directed_rows[i].it, directed_rows[i].has_fixed, directed_rows[i].fixed);
        if (m_pending)
            fill_block(0);
        while (sent_count < 600)
            random_lookup();
        // stray fills with no block pending
        for (int n = 0; n < 8; n++)
            send_item(make_fill($urandom), 0, '0);
        in_valid <= 1'b0;
        @(posedge clk);
        done_sending = 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (long_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 9) < 7);
    end

    initial
    begin
        long_hold = 1'b0;
        wait (sent_count >= 300);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (200) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", out_item);
            end
            else
            begin
                out_item_t e;
                e = expected_results.pop_front();
                if (e.status != out_item.status || e.out_texel != out_item.out_texel
                    || e.req_texture_id != out_item.req_texture_id
                    || e.req_level != out_item.req_level
                    || e.req_block_x != out_item.req_block_x
                    || e.req_block_y != out_item.req_block_y)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", e, out_item);
                end
            end
        end
    end

    initial
    begin
        wait (done_sending);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
